/* src/et_pkg.sv */
package et_pkg;

  // default width of the character position counter
  localparam int unsigned POS_BITS_DEF = 16;

  // token groups buffered between the scanner and the output stage
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 40;

  typedef enum logic [3:0] {
    TK_END      = 4'd0,
    TK_NUMBER   = 4'd1,
    TK_IDENT    = 4'd2,
    TK_PLUS     = 4'd3,
    TK_MINUS    = 4'd4,
    TK_STAR     = 4'd5,
    TK_SLASH    = 4'd6,
    TK_STARSTAR = 4'd7,
    TK_CARET    = 4'd8,
    TK_LPAREN   = 4'd9,
    TK_RPAREN   = 4'd10,
    TK_COMMA    = 4'd11,
    TK_ERROR    = 4'd12
  } token_kind_e;

  typedef struct packed {
    token_kind_e kind;
    logic [15:0] start;
    logic [15:0] len;
  } token_t;

  // all tokens caused by one input item, cnt is 1 or 2
  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } group_t;

endpackage

/* src/et_front.sv */
module et_front #(
  parameter int unsigned PosBits = et_pkg::POS_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     char_i,
  input  logic           eos_i,
  input  logic           q_full_i,
  output logic           push_o,
  output et_pkg::group_t grp_o
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_NUMBER = 3'd1;
  localparam logic [2:0] MODE_IDENT  = 3'd2;
  localparam logic [2:0] MODE_STAR   = 3'd3;
  localparam logic [2:0] MODE_HALT   = 3'd4;

  localparam int unsigned SatW = PosBits + 1;
  localparam logic [SatW-1:0] SatLim = SatW'(17'h0FFFF);

  function automatic logic [15:0] sat16(input logic [PosBits-1:0] v);
    logic [15:0] r;
    if ({1'b0, v} > SatLim) r = 16'hFFFF;
    else                    r = 16'(v);
    return r;
  endfunction

  logic [2:0]         mode_q, mode_d;
  logic               dot_q, dot_d;
  logic               exp_q, exp_d;
  logic               jae_q, jae_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] tstart_q, tstart_d;

  logic accept;
  logic is_digit, is_alpha, is_space, is_dot, is_e, is_star, is_us, is_pm;
  logic id_char;

  // outcome of a character that opens a new token
  logic [2:0]          st_mode;
  logic                st_emit;
  et_pkg::token_kind_e st_kind;

  logic                fl_valid, sec_valid;
  et_pkg::token_t      fl_tok, sec_tok;
  logic                do_start;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_digit = (char_i >= 8'h30) && (char_i <= 8'h39);
    is_alpha = ((char_i >= 8'h61) && (char_i <= 8'h7A)) ||
               ((char_i >= 8'h41) && (char_i <= 8'h5A));
    is_space = (char_i == 8'h20) || ((char_i >= 8'h09) && (char_i <= 8'h0D));
    is_dot   = (char_i == 8'h2E);
    is_e     = (char_i == 8'h65) || (char_i == 8'h45);
    is_star  = (char_i == 8'h2A);
    is_us    = (char_i == 8'h5F);
    is_pm    = (char_i == 8'h2B) || (char_i == 8'h2D);
    id_char  = is_alpha || is_digit || is_us;
  end

  always_comb begin
    st_emit = 1'b0;
    st_kind = et_pkg::TK_ERROR;
    st_mode = MODE_IDLE;
    if (is_space) begin
      st_mode = MODE_IDLE;
    end else if (is_digit || is_dot) begin
      st_mode = MODE_NUMBER;
    end else if (is_alpha || is_us) begin
      st_mode = MODE_IDENT;
    end else if (is_star) begin
      st_mode = MODE_STAR;
    end else begin
      st_emit = 1'b1;
      unique case (char_i)
        8'h2B:   st_kind = et_pkg::TK_PLUS;
        8'h2D:   st_kind = et_pkg::TK_MINUS;
        8'h2F:   st_kind = et_pkg::TK_SLASH;
        8'h5E:   st_kind = et_pkg::TK_CARET;
        8'h28:   st_kind = et_pkg::TK_LPAREN;
        8'h29:   st_kind = et_pkg::TK_RPAREN;
        8'h2C:   st_kind = et_pkg::TK_COMMA;
        default: st_kind = et_pkg::TK_ERROR;
      endcase
      st_mode = (st_kind == et_pkg::TK_ERROR) ? MODE_HALT : MODE_IDLE;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    dot_d    = dot_q;
    exp_d    = exp_q;
    jae_d    = jae_q;
    tstart_d = tstart_q;
    pos_d    = (pos_q == '1) ? pos_q : pos_q + PosBits'(1);
    do_start = 1'b0;

    fl_valid      = 1'b0;
    fl_tok.kind   = et_pkg::TK_NUMBER;
    fl_tok.start  = sat16(tstart_q);
    fl_tok.len    = sat16(pos_q - tstart_q);
    sec_valid     = 1'b0;
    sec_tok.kind  = st_kind;
    sec_tok.start = sat16(pos_q);
    sec_tok.len   = 16'd1;

    if (eos_i) begin
      // flush the pending token, then end, then clear everything
      unique case (mode_q)
        MODE_NUMBER: fl_valid = 1'b1;
        MODE_IDENT: begin
          fl_valid    = 1'b1;
          fl_tok.kind = et_pkg::TK_IDENT;
        end
        MODE_STAR: begin
          fl_valid    = 1'b1;
          fl_tok.kind = et_pkg::TK_STAR;
          fl_tok.len  = 16'd1;
        end
        default: fl_valid = 1'b0;
      endcase
      sec_valid    = 1'b1;
      sec_tok.kind = et_pkg::TK_END;
      sec_tok.len  = 16'd0;
      mode_d       = MODE_IDLE;
      dot_d        = 1'b0;
      exp_d        = 1'b0;
      jae_d        = 1'b0;
      pos_d        = '0;
      tstart_d     = '0;
    end else begin
      unique case (mode_q)
        MODE_NUMBER: begin
          jae_d = 1'b0;
          if (is_digit || (jae_q && is_pm)) begin
            mode_d = MODE_NUMBER;
          end else if (is_dot && !dot_q && !exp_q) begin
            dot_d = 1'b1;
          end else if (is_e && !exp_q) begin
            exp_d = 1'b1;
            jae_d = 1'b1;
          end else begin
            fl_valid = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (!id_char) begin
            fl_valid    = 1'b1;
            fl_tok.kind = et_pkg::TK_IDENT;
            do_start    = 1'b1;
          end
        end
        MODE_STAR: begin
          fl_valid   = 1'b1;
          fl_tok.len = 16'd1;
          if (is_star) begin
            fl_tok.kind = et_pkg::TK_STARSTAR;
            fl_tok.len  = 16'd2;
            mode_d      = MODE_IDLE;
          end else begin
            fl_tok.kind = et_pkg::TK_STAR;
            do_start    = 1'b1;
          end
        end
        MODE_IDLE: do_start = 1'b1;
        default:   mode_d = MODE_HALT;
      endcase

      if (do_start) begin
        mode_d    = st_mode;
        sec_valid = st_emit;
        dot_d     = (st_mode == MODE_NUMBER) && is_dot;
        exp_d     = 1'b0;
        jae_d     = 1'b0;
        if (!st_emit && !is_space) tstart_d = pos_q;
      end
    end
  end

  always_comb begin
    grp_o = '0;
    if (fl_valid) begin
      grp_o.cnt  = sec_valid ? 2'd2 : 2'd1;
      grp_o.tok0 = fl_tok;
      grp_o.tok1 = sec_tok;
    end else begin
      grp_o.cnt  = sec_valid ? 2'd1 : 2'd0;
      grp_o.tok0 = sec_tok;
      grp_o.tok1 = sec_tok;
    end
  end

  assign push_o = accept && (grp_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      dot_q    <= 1'b0;
      exp_q    <= 1'b0;
      jae_q    <= 1'b0;
      pos_q    <= '0;
      tstart_q <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      dot_q    <= dot_d;
      exp_q    <= exp_d;
      jae_q    <= jae_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
    end
  end

endmodule

/* src/et_queue.sv */
module et_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  et_pkg::group_t grp_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output et_pkg::group_t head_o
);

  et_pkg::group_t mem_q [et_pkg::Q_DEPTH];

  logic [et_pkg::Q_AW-1:0] wr_q, rd_q;
  logic [et_pkg::Q_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (et_pkg::Q_AW+1)'(et_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= grp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + (et_pkg::Q_AW)'(1);
      if (pop_i)  rd_q <= rd_q + (et_pkg::Q_AW)'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (et_pkg::Q_AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (et_pkg::Q_AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* src/et_back.sv */
module et_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  et_pkg::group_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output et_pkg::token_t out_tok_o,
  output logic           out_last_o
);

  logic           vld_q;
  logic           idx_q;
  et_pkg::token_t tok_q;
  logic           last_q;

  logic           load, take, cur_last;
  et_pkg::token_t cur_tok;

  assign load     = !vld_q || out_ready_i;
  assign take     = load && !empty_i;
  assign cur_tok  = idx_q ? head_i.tok1 : head_i.tok0;
  // second token, or the only one of a group, closes the item
  assign cur_last = idx_q || (head_i.cnt == 2'd1);
  assign pop_o    = take && cur_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 1'b0;
    end else begin
      if (load) vld_q <= !empty_i;
      if (take) idx_q <= !cur_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tok_q  <= cur_tok;
      last_q <= cur_last;
    end
  end

  assign out_valid_o = vld_q;
  assign out_tok_o   = tok_q;
  assign out_last_o  = last_q;

endmodule

/* src/expression_tokenizer.sv */
// streaming lexer for arithmetic expressions
// input channel (s_axis): one source byte per item in tdata, tlast marks the
// end of source; an end item flushes a pending token, emits an end token and
// clears the scanner, including the character count
// output channel (m_axis): one token per item, tdata carries kind, start
// position and length, tlast is set on the last token caused by an input item
// a token reaches m_axis through the queue and the output register: the queue
// is written at the edge that accepts the character that completes it, and the
// output register loads from the queue once it is free; a second token follows
// throughput: one character per cycle while each causes at most one token and
// the queue has room; the two tokens of a character that causes two leave in
// turn, and the scanner keeps going while the four-entry token queue has room
// reset clears the scanner, the queue and the output valid flag; characters
// after an error are counted but cause no tokens until the end item
// when the receiver stalls the output register holds, the queue fills and
// s_axis_tready_o drops once the queue is full
module expression_tokenizer #(
  parameter int unsigned PosBits = et_pkg::POS_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [et_pkg::TDATA_IN_W-1:0]  s_axis_tdata_i,  // [7:0] char_code
  input  logic                           s_axis_tlast_i,  // end_of_source
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [3:0] token_kind, [19:4] start_pos, [35:20] token_len, [39:36] zero
  output logic [et_pkg::TDATA_OUT_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o   // last_of_run
);

  logic           push, full, pop, empty;
  et_pkg::group_t grp, head;
  et_pkg::token_t out_tok;

  et_front #(
    .PosBits(PosBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .char_i    (s_axis_tdata_i),
    .eos_i     (s_axis_tlast_i),
    .q_full_i  (full),
    .push_o    (push),
    .grp_o     (grp)
  );

  et_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .grp_i  (grp),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head)
  );

  et_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_tok_o  (out_tok),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, out_tok.len, out_tok.start, out_tok.kind};

endmodule
